### hdl/cscv_pkg.sv
package cscv_pkg;

    // input commands
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_VEC   = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // configuration register indexes
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    localparam int VALUE_W = 32;
    localparam int ROW_W   = 6;
    localparam int CFG_W   = 7;

    // saturating Q16.16 add of a truncated product to an accumulator
    function automatic logic signed [31:0] sat_add(
        input logic signed [31:0] acc,
        input logic signed [47:0] prod_shr
    );
        logic signed [48:0] sum;
        sum = {{17{acc[31]}}, acc} + {prod_shr[47], prod_shr};
        if (sum > 49'sd2147483647)
            sat_add = 32'sh7fffffff;
        else if (sum < -49'sd2147483648)
            sat_add = 32'sh80000000;
        else
            sat_add = sum[31:0];
    endfunction

endpackage

### hdl/cscv_ram.sv
module cscv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

### hdl/cscv_mac.sv
module cscv_mac (
    input  logic               aclk,
    input  logic signed [31:0] factor,
    input  logic signed [31:0] value,
    input  logic signed [31:0] acc,
    output logic signed [47:0] prod_shr_reg,
    output logic signed [31:0] sum
);
    logic signed [63:0] prod;

    // shared multiplier, product registered before the add
    assign prod = factor * value;
    always_ff @(posedge aclk) begin
        prod_shr_reg <= prod[63:16];
    end

    assign sum = cscv_pkg::sat_add(acc, prod_shr_reg);
endmodule

### hdl/csc_sparse_matrix_vector_product_unit.sv
// Channel | Dir | tdata (low bit up)                          | tuser / tlast
// s_      | in  | column_index[5:0] entry_row[11:6] value[43:12] | tuser = cmd
// m_      | out | result_row[5:0] result_value[37:6]          | tlast, tuser = load_error
// A push writes the column boundaries it moves past, then stores the entry; clear resets
// the entry count, current column and error flag; a dropped push or an ignored vector entry
// returns straight to idle. A vector entry reads its column bounds, then for each stored
// entry does memory read, multiply, accumulate in one shared MAC. End walks all MAX_ROWS
// accumulators, sending the configured rows. After reset a clearing pass zeroes accumulators
// and column starts; no request is taken meanwhile. Output stalls hold the sequencer.
module csc_sparse_matrix_vector_product_unit #(
    parameter int MAX_NNZ  = 1024,
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // column_index, entry_row, operand_value
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_row, result_value
    output logic        m_tlast,   // last
    output logic        m_tuser    // load_error
);
    localparam int AW  = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
    localparam int CW  = $clog2(MAX_NNZ + 1);
    localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int KW  = $clog2(MAX_COLS + 1);
    localparam int CAW = $clog2(MAX_COLS + 1);
    localparam int SW  = $clog2(MAX_ROWS + 2);

    localparam logic [3:0] ST_INIT = 4'd0, ST_IDLE = 4'd1, ST_FILL = 4'd2,
        ST_VS1 = 4'd3, ST_VS2 = 4'd4, ST_VRD = 4'd5, ST_VMUL = 4'd6,
        ST_VACC = 4'd7, ST_ERD = 4'd8, ST_EOUT = 4'd9, ST_VS0 = 4'd10;

    logic [3:0]  state_reg, state_next;
    logic [6:0]  rows_reg, cols_reg;
    logic [CW-1:0] count_reg;
    logic [KW-1:0] curcol_reg, k_reg;
    logic        err_reg;
    logic [SW-1:0] init_reg;
    logic [CW-1:0] e_reg, end_reg;
    logic [5:0]  col_reg, row_reg;
    logic signed [31:0] val_reg;
    logic [RAW-1:0] r_reg;
    logic [6:0]  n_reg;

    logic [5:0]  in_col, in_row;
    logic signed [31:0] in_val;
    logic [6:0]  eff_rows, eff_cols;
    assign in_col = s_tdata[5:0];
    assign in_row = s_tdata[11:6];
    assign in_val = s_tdata[43:12];
    assign eff_rows = (32'(rows_reg) > MAX_ROWS) ? 7'(MAX_ROWS) : rows_reg;
    assign eff_cols = (32'(cols_reg) > MAX_COLS) ? 7'(MAX_COLS) : cols_reg;

    // matrix entry stores
    logic ent_we;
    logic [AW-1:0] ent_raddr;
    logic signed [31:0] ent_val;
    logic [5:0] ent_row;
    cscv_ram #(.WIDTH(32), .DEPTH(MAX_NNZ)) u_vals (.aclk, .we(ent_we),
        .waddr(count_reg[AW-1:0]), .wdata(val_reg), .raddr(ent_raddr), .rdata(ent_val));
    cscv_ram #(.WIDTH(6), .DEPTH(MAX_NNZ)) u_rows (.aclk, .we(ent_we),
        .waddr(count_reg[AW-1:0]), .wdata(row_reg), .raddr(ent_raddr), .rdata(ent_row));

    // column starts
    logic cs_we;
    logic [CAW-1:0] cs_waddr, cs_raddr;
    logic [CW-1:0] cs_wdata, cs_rdata;
    cscv_ram #(.WIDTH(CW), .DEPTH(MAX_COLS + 1)) u_cs (.aclk, .we(cs_we),
        .waddr(cs_waddr), .wdata(cs_wdata), .raddr(cs_raddr), .rdata(cs_rdata));

    // accumulators
    logic acc_we;
    logic [RAW-1:0] acc_waddr, acc_raddr;
    logic signed [31:0] acc_wdata, acc_rdata;
    cscv_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_acc (.aclk, .we(acc_we),
        .waddr(acc_waddr), .wdata(acc_wdata), .raddr(acc_raddr), .rdata(acc_rdata));

    logic signed [47:0] prod_shr;
    logic signed [31:0] mac_sum;
    cscv_mac u_mac (.aclk, .factor(val_reg), .value(ent_val), .acc(acc_rdata),
        .prod_shr_reg(prod_shr), .sum(mac_sum));

    logic s_fire, push_bad;
    assign s_fire = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign push_bad = (32'(count_reg) >= MAX_NNZ) || ({1'b0, in_row} >= eff_rows)
        || ({1'b0, in_col} >= eff_cols) || (KW'(in_col) < curcol_reg);

    // output register
    logic out_free, out_load;
    assign out_free = !m_tvalid || m_tready;
    assign out_load = (state_reg == ST_EOUT) && out_free && (7'(r_reg) < n_reg);

    // sequencer
    always_comb begin
        state_next = state_reg;
        ent_we = 1'b0; cs_we = 1'b0; acc_we = 1'b0;
        cs_waddr = CAW'(k_reg); cs_wdata = count_reg; cs_raddr = CAW'(col_reg);
        acc_waddr = r_reg; acc_wdata = mac_sum; acc_raddr = r_reg;
        ent_raddr = e_reg[AW-1:0];
        unique case (state_reg)
            ST_INIT: begin
                cs_we = 1'b1; cs_waddr = CAW'(init_reg); cs_wdata = '0;
                acc_we = (32'(init_reg) < MAX_ROWS);
                acc_waddr = RAW'(init_reg); acc_wdata = '0;
                if (32'(init_reg) == MAX_ROWS) state_next = ST_IDLE;
            end
            ST_IDLE: if (s_fire) begin
                unique case (s_tuser)
                    cscv_pkg::CMD_PUSH:  state_next = (push_bad) ? ST_IDLE : ST_FILL;
                    cscv_pkg::CMD_VEC:
                        state_next = ({1'b0, in_col} >= eff_cols) ? ST_IDLE : ST_VS0;
                    cscv_pkg::CMD_END:   state_next = ST_ERD;
                    cscv_pkg::CMD_CLEAR: state_next = ST_INIT;
                endcase
            end
            ST_FILL: begin
                // column boundaries up to the new column
                if (k_reg <= KW'(col_reg)) cs_we = 1'b1;
                else begin
                    ent_we = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_VS0: begin
                cs_raddr = CAW'(col_reg);
                state_next = ST_VS1;
            end
            ST_VS1: begin
                cs_raddr = CAW'(col_reg) + CAW'(1);
                state_next = ST_VS2;
            end
            ST_VS2: state_next = ST_VRD;
            ST_VRD: begin
                if (e_reg >= end_reg || 32'(e_reg) >= MAX_NNZ) state_next = ST_IDLE;
                else state_next = ST_VMUL;
            end
            ST_VMUL: begin
                acc_raddr = ent_row[RAW-1:0];
                state_next = ST_VACC;
            end
            ST_VACC: begin
                acc_we = 1'b1;
                state_next = ST_VRD;
                ent_raddr = e_reg[AW-1:0];
            end
            ST_ERD: begin
                if (n_reg == '0) acc_we = 1'b0;
                state_next = ST_EOUT;
            end
            ST_EOUT: if (out_free) begin
                acc_we = 1'b1; acc_wdata = '0;
                state_next = (32'(r_reg) == MAX_ROWS - 1) ? ST_IDLE : ST_ERD;
                acc_raddr = RAW'(r_reg + RAW'(1));
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT; init_reg <= '0;
            rows_reg <= 7'd64; cols_reg <= 7'd64;
            count_reg <= '0; curcol_reg <= '0; err_reg <= 1'b0;
            m_tvalid <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) m_tvalid <= 1'b1;
            else if (m_tready) m_tvalid <= 1'b0;
            if (cfg_we) begin
                if (cfg_index == cscv_pkg::REG_NUM_ROWS) rows_reg <= cfg_wdata;
                else cols_reg <= cfg_wdata;
            end
            unique case (state_reg)
                ST_INIT: init_reg <= init_reg + SW'(1);
                ST_IDLE: if (s_fire) begin
                    col_reg <= in_col; row_reg <= in_row; val_reg <= in_val;
                    k_reg <= curcol_reg + KW'(1);
                    r_reg <= '0; n_reg <= eff_rows;
                    if (s_tuser == cscv_pkg::CMD_PUSH && push_bad) err_reg <= 1'b1;
                    if (s_tuser == cscv_pkg::CMD_CLEAR) begin
                        count_reg <= '0; curcol_reg <= '0; err_reg <= 1'b0;
                        init_reg <= SW'(MAX_ROWS);
                    end
                end
                ST_FILL: begin
                    if (k_reg <= KW'(col_reg)) k_reg <= k_reg + KW'(1);
                    else begin
                        curcol_reg <= KW'(col_reg);
                        count_reg <= count_reg + CW'(1);
                    end
                end
                ST_VS1: e_reg <= (KW'(col_reg) <= curcol_reg) ? cs_rdata : count_reg;
                ST_VS2: end_reg <= (KW'(col_reg) < curcol_reg) ? cs_rdata : count_reg;
                ST_VMUL: r_reg <= ent_row[RAW-1:0];
                ST_VACC: e_reg <= e_reg + CW'(1);
                ST_EOUT: if (out_free) begin
                    if (out_load) begin
                        m_tdata <= {2'b00, acc_rdata, 6'(r_reg)};
                        m_tlast <= (7'(r_reg) + 7'd1 == n_reg);
                        m_tuser <= err_reg;
                    end
                    r_reg <= r_reg + RAW'(1);
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("busy accept");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))) else $error("out lost");
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= MAX_NNZ) else $error("count overflow");
`endif
endmodule

### tb/csc_sparse_matrix_vector_product_unit_test.sv
module csc_sparse_matrix_vector_product_unit_test;

    localparam int NNZ_CAP  = 1024;
    localparam int ROW_CAP  = 64;
    localparam int COL_CAP  = 64;
    localparam int RAND_ITEMS = 245;

    typedef struct packed {
        logic [5:0]  row;
        logic [31:0] value;
        logic        last;
        logic        load_err;
    } product_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [31:0] value;
    } request_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;     // column_index, entry_row, operand_value
    logic [1:0]  s_tuser = '0;     // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // result_row, result_value
    logic        m_tlast;
    logic        m_tuser;          // load_error

    csc_sparse_matrix_vector_product_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // shadow of the block's matrix and accumulators
    logic signed [31:0] mat_value [NNZ_CAP];
    logic [5:0]         mat_row [NNZ_CAP];
    int unsigned        col_start [COL_CAP+1];
    int unsigned        nnz;
    int unsigned        cur_col;
    logic signed [31:0] acc [ROW_CAP];
    logic               load_err;
    int unsigned        rows_cfg = 64;
    int unsigned        cols_cfg = 64;

    product_t expected_products [$];
    int  mismatches = 0;
    bit  idle_free = 1'b0;

    function automatic void clear_shadow();
        foreach (col_start[k]) col_start[k] = 0;
        nnz = 0;
        cur_col = 0;
        load_err = 1'b0;
    endfunction

    // floor(a*b / 2^16) then saturating add
    function automatic logic signed [31:0] mac_sat(logic signed [31:0] a_acc,
                                                   logic signed [31:0] f,
                                                   logic signed [31:0] v);
        logic signed [63:0] p;
        logic signed [65:0] s;
        p = f * v;
        s = $signed({{2{a_acc[31]}}, {32{a_acc[31]}}, a_acc}) + (p >>> 16);
        if (s > 66'sd2147483647) return 32'sh7fffffff;
        if (s < -66'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction

    // update shadow state for one request, queue any products it yields
    function automatic void predict_products(request_t q);
        int unsigned eff_r, eff_c, first, stop;
        eff_r = (rows_cfg > ROW_CAP) ? ROW_CAP : rows_cfg;
        eff_c = (cols_cfg > COL_CAP) ? COL_CAP : cols_cfg;
        case (q.cmd)
            cscv_pkg::CMD_PUSH: begin
                if (nnz >= NNZ_CAP || 32'(q.row) >= eff_r || 32'(q.col) >= eff_c
                    || 32'(q.col) < cur_col) begin
                    load_err = 1'b1;
                end else begin
                    for (int unsigned k = cur_col + 1; k <= 32'(q.col); k++)
                        col_start[k] = nnz;
                    cur_col = 32'(q.col);
                    mat_value[nnz] = q.value;
                    mat_row[nnz] = q.row;
                    nnz++;
                end
            end
            cscv_pkg::CMD_VEC: begin
                if (32'(q.col) < eff_c) begin
                    first = (32'(q.col) <= cur_col) ? col_start[q.col] : nnz;
                    stop  = (32'(q.col) < cur_col) ? col_start[32'(q.col) + 1] : nnz;
                    for (int unsigned e = first; e < stop; e++)
                        acc[mat_row[e]] = mac_sat(acc[mat_row[e]], q.value, mat_value[e]);
                end
            end
            cscv_pkg::CMD_END: begin
                for (int unsigned r = 0; r < eff_r; r++)
                    expected_products.push_back('{row: r[5:0], value: acc[r],
                        last: (r + 1 == eff_r), load_err: load_err});
                foreach (acc[r]) acc[r] = '0;
            end
            default: clear_shadow();
        endcase
    endfunction

    // result side: random stalls, compare in order
    always @(posedge aclk) begin
        product_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{row: m_tdata[5:0], value: m_tdata[37:6], last: m_tlast, load_err: m_tuser};
            if (expected_products.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected product %p", got);
            end else begin
                want = expected_products.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("product mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(negedge aclk)
        m_tready <= idle_free || ($urandom_range(99) >= 37);

    // drive one request; returns at the falling edge after it is taken
    task automatic send_request(request_t q);
        while (!idle_free && $urandom_range(99) < 37) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= q.cmd;
        s_tdata <= {4'b0000, q.value, q.row, q.col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_products(q);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_products.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[6:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        if (idx == cscv_pkg::REG_NUM_ROWS) rows_cfg = val; else cols_cfg = val;
    endtask

    // random request mix: mostly well-ordered column loads and vector walks, with some ends and clears
    task automatic random_phase(int n);
        request_t q;
        int unsigned c;
        c = 0;
        for (int i = 0; i < n; i++) begin
            int unsigned pick;
            pick = $urandom_range(99);
            q.value = $urandom();
            if (pick < 5) q.value = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            q.row = 6'(($urandom_range(7) == 0) ? $urandom_range(63)
                                                 : $urandom_range(rows_cfg - 1));
            if (pick < 45) begin
                q.cmd = cscv_pkg::CMD_PUSH;
                if ($urandom_range(9) != 0) c = c + $urandom_range(1);
                if (c > 63) c = 63;
                q.col = 6'(($urandom_range(19) == 0) ? $urandom_range(63) : c);
            end else if (pick < 85) begin
                q.cmd = cscv_pkg::CMD_VEC;
                q.col = 6'(($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(c));
            end else if (pick < 96) begin
                q.cmd = cscv_pkg::CMD_END;
                q.col = 6'($urandom_range(63));
            end else begin
                q.cmd = cscv_pkg::CMD_CLEAR;
                q.col = 6'($urandom_range(63));
                c = 0;
            end
            send_request(q);
        end
        q = '{cmd: cscv_pkg::CMD_END, col: 6'd0, row: 6'd0, value: 32'd0};
        send_request(q);
    endtask

    // directed rows
    request_t directed [] = '{
        '{cscv_pkg::CMD_END,   6'd0,  6'd0,  32'd0},          // after reset: all zeros
        '{cscv_pkg::CMD_PUSH,  6'd0,  6'd0,  32'h7fffffff},
        '{cscv_pkg::CMD_PUSH,  6'd0,  6'd0,  32'h7fffffff},   // repeated row adds twice
        '{cscv_pkg::CMD_PUSH,  6'd0,  6'd63, 32'h80000000},
        '{cscv_pkg::CMD_PUSH,  6'd2,  6'd5,  32'h00010000},   // skips column 1
        '{cscv_pkg::CMD_PUSH,  6'd1,  6'd5,  32'h00010000},   // column going back: dropped
        '{cscv_pkg::CMD_PUSH,  6'd63, 6'd1,  32'hffff0000},
        '{cscv_pkg::CMD_VEC,   6'd0,  6'd0,  32'h7fffffff},   // saturates high
        '{cscv_pkg::CMD_VEC,   6'd1,  6'd0,  32'h00020000},   // empty column
        '{cscv_pkg::CMD_VEC,   6'd2,  6'd0,  32'hffffffff},   // floor of negative product
        '{cscv_pkg::CMD_VEC,   6'd63, 6'd0,  32'h80000000},
        '{cscv_pkg::CMD_VEC,   6'd40, 6'd0,  32'h00010000},   // empty column below current
        '{cscv_pkg::CMD_END,   6'd0,  6'd0,  32'd0},
        '{cscv_pkg::CMD_VEC,   6'd0,  6'd0,  32'h80000000},   // saturates low
        '{cscv_pkg::CMD_CLEAR, 6'd0,  6'd0,  32'd0},          // accumulators survive clear
        '{cscv_pkg::CMD_END,   6'd0,  6'd0,  32'd0},
        '{cscv_pkg::CMD_PUSH,  6'd5,  6'd3,  32'h00018000},
        '{cscv_pkg::CMD_VEC,   6'd5,  6'd0,  32'h00008000},
        '{cscv_pkg::CMD_END,   6'd63, 6'd63, 32'hffffffff}
    };

    initial begin
        request_t q;
        foreach (acc[r]) acc[r] = '0;
        clear_shadow();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // directed walk at reset configuration
        foreach (directed[i]) send_request(directed[i]);
        drain();

        // small sizes: out-of-range rows/columns exercise the error flag
        write_reg(cscv_pkg::REG_NUM_ROWS, 1);
        write_reg(cscv_pkg::REG_NUM_COLS, 1);
        q = '{cmd: cscv_pkg::CMD_PUSH, col: 6'd0, row: 6'd1, value: 32'h1};
        send_request(q);
        q = '{cmd: cscv_pkg::CMD_PUSH, col: 6'd1, row: 6'd0, value: 32'h1};
        send_request(q);
        q = '{cmd: cscv_pkg::CMD_VEC, col: 6'd1, row: 6'd0, value: 32'h1};
        send_request(q);
        q = '{cmd: cscv_pkg::CMD_END, col: 6'd0, row: 6'd0, value: 32'h0};
        send_request(q);
        drain();

        // zero rows emit nothing; oversized counts clamp
        write_reg(cscv_pkg::REG_NUM_ROWS, 0);
        write_reg(cscv_pkg::REG_NUM_COLS, 127);
        q = '{cmd: cscv_pkg::CMD_CLEAR, col: 6'd0, row: 6'd0, value: 32'h0};
        send_request(q);
        q = '{cmd: cscv_pkg::CMD_END, col: 6'd0, row: 6'd0, value: 32'h0};
        send_request(q);
        drain();
        write_reg(cscv_pkg::REG_NUM_ROWS, 127);
        send_request(q);
        drain();

        // random phases over several configurations
        write_reg(cscv_pkg::REG_NUM_ROWS, 8);
        write_reg(cscv_pkg::REG_NUM_COLS, 16);
        send_request('{cmd: cscv_pkg::CMD_CLEAR, col: 6'd0, row: 6'd0, value: 32'h0});
        random_phase(RAND_ITEMS / 3);
        drain();

        idle_free = 1'b1;
        write_reg(cscv_pkg::REG_NUM_ROWS, 64);
        write_reg(cscv_pkg::REG_NUM_COLS, 64);
        send_request('{cmd: cscv_pkg::CMD_CLEAR, col: 6'd0, row: 6'd0, value: 32'h0});
        random_phase(RAND_ITEMS / 3);
        idle_free = 1'b0;
        drain();

        write_reg(cscv_pkg::REG_NUM_ROWS, $urandom_range(1, 20));
        write_reg(cscv_pkg::REG_NUM_COLS, $urandom_range(1, 20));
        random_phase(RAND_ITEMS / 3);
        drain();

        if (mismatches == 0 && expected_products.size() == 0) begin
            $display("csc_sparse_matrix_vector_product_unit test passed");
        end else begin
            $display("csc_sparse_matrix_vector_product_unit test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("csc_sparse_matrix_vector_product_unit test failed");
        $finish;
    end

endmodule
